// ----- rtl/tspib_pkg.sv -----
package tspib_pkg;

	localparam int MAX_NODES_DEF = 32;
	localparam int DIST_BITS_DEF = 24;
	localparam int NODE_W        = 6;
	localparam int IN_DIST_W     = 24;
	localparam int LEN_W         = 29;
	localparam int APB_AW        = 3;
	localparam int APB_DW        = 32;

	localparam logic [LEN_W-1:0]  LEN_MAX        = {LEN_W{1'b1}};
	// 1000000.0 in Q.8
	localparam logic [27:0]       BIG_LIMIT      = 28'd256000000;
	localparam logic [NODE_W-1:0] NODE_COUNT_RST = 6'd32;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_RUN   = 1'b1;
	localparam logic MODE_FAR  = 1'b0;
	localparam logic MODE_NEAR = 1'b1;
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef logic [NODE_W-1:0] node_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_CHK,
		ST_SEL,
		ST_SEL_END,
		ST_INS_CHK,
		ST_INS_RB,
		ST_INS_RC,
		ST_INS_CMP,
		ST_LINK,
		ST_LEN_CHK,
		ST_LEN_ACC,
		ST_EMIT_INIT,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		RD_UPD,
		RD_A,
		RD_B,
		RD_C,
		RD_LEN
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    start;
		logic    idx_clr;
		logic    idx_inc;
		logic    step_inc;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    upd_wr;
		logic    sel_init;
		logic    sel_eval;
		logic    set_flag;
		logic    ins_init;
		logic    cap_a;
		logic    cap_b;
		logic    ins_cmp;
		logic    link;
		logic    len_acc;
		logic    emit_init;
		logic    emit_load;
	} dp_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic step_done;
		logic pick_zero;
		logic ins_ok;
		logic len_ok;
		logic emit_done;
		logic out_free;
	} dp_sts_t;

endpackage

// ----- rtl/tsp_insertion_tour_builder_unit.sv -----
// Channel   Beat carries                                         Handshake
// input     command, row_node, col_node, distance_value           in_valid / in_stall
// output    tour_node, tour_length, last                          out_valid / out_stall
// config    selection_mode @ 0x0, node_count @ 0x4                APB, pready tied high
//
// A load beat writes the distance into the table memory at acceptance.
// During a run beat every table access goes through the single registered read port of the
// distance memory, one access per state.
// The tour then leaves as n+1 beats, one per cycle when the output is not stalled.
// Reset needs no clearing pass; the user must write the distance table wherever it is read (not enforced).
// A stall on the output holds the beat in its register; the input stays stalled until done.
module tsp_insertion_tour_builder_unit #(
	parameter int MAX_NODES = tspib_pkg::MAX_NODES_DEF,
	parameter int DIST_BITS = tspib_pkg::DIST_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  tspib_pkg::node_t                row_node,
	input  tspib_pkg::node_t                col_node,
	input  logic [tspib_pkg::IN_DIST_W-1:0] distance_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tspib_pkg::node_t                tour_node,
	output logic [tspib_pkg::LEN_W-1:0]     tour_length,
	output logic                            last,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tspib_pkg::APB_AW-1:0]    paddr,
	input  logic [tspib_pkg::APB_DW-1:0]    pwdata,
	output logic [tspib_pkg::APB_DW-1:0]    prdata,
	output logic                            pready
);
	import tspib_pkg::*;

	logic    selection_mode_q;
	node_t   node_count_q;
	logic    cfg_wr;
	dp_cmd_t cmd;
	dp_sts_t sts;

	// Registers sit on word addresses; bit 2 of the address selects between the two.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			selection_mode_q <= MODE_FAR;
			node_count_q     <= NODE_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MODE:  selection_mode_q <= pwdata[0];
				REG_COUNT: node_count_q     <= pwdata[NODE_W-1:0];
				default:   selection_mode_q <= selection_mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE:  prdata = {{(APB_DW-1){1'b0}}, selection_mode_q};
			REG_COUNT: prdata = {{(APB_DW-NODE_W){1'b0}}, node_count_q};
			default:   prdata = '0;
		endcase
	end

	// The controller sequences the build; the datapath holds the table and all tour state.
	tspib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tspib_dp #(
		.MAX_NODES (MAX_NODES),
		.DIST_BITS (DIST_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.selection_mode (selection_mode_q),
		.node_count     (node_count_q),
		.row_node       (row_node),
		.col_node       (col_node),
		.distance_value (distance_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tour_node      (tour_node),
		.tour_length    (tour_length),
		.last           (last)
	);

endmodule

// ----- rtl/tspib_ctrl.sv -----
module tspib_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              command,
	output logic              in_stall,
	input  tspib_pkg::dp_sts_t sts,
	output tspib_pkg::dp_cmd_t cmd
);
	import tspib_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && command == CMD_RUN) state_d = ST_START;
			end
			ST_START:   state_d = ST_UPD_RD;
			ST_UPD_RD:  state_d = ST_UPD_WR;
			ST_UPD_WR:  state_d = sts.idx_last ? ST_CHK : ST_UPD_RD;
			ST_CHK:     state_d = sts.step_done ? ST_LEN_CHK : ST_SEL;
			ST_SEL:     state_d = sts.idx_last ? ST_SEL_END : ST_SEL;
			ST_SEL_END: state_d = sts.pick_zero ? ST_CHK : ST_INS_CHK;
			ST_INS_CHK: begin
				if (sts.ins_ok) state_d = ST_INS_RB;
				else if (sts.idx_last) state_d = ST_LINK;
			end
			ST_INS_RB:  state_d = ST_INS_RC;
			ST_INS_RC:  state_d = ST_INS_CMP;
			ST_INS_CMP: state_d = sts.idx_last ? ST_LINK : ST_INS_CHK;
			ST_LINK:    state_d = ST_UPD_RD;
			ST_LEN_CHK: begin
				if (sts.len_ok) state_d = ST_LEN_ACC;
				else if (sts.idx_last) state_d = ST_EMIT_INIT;
			end
			ST_LEN_ACC:   state_d = sts.idx_last ? ST_EMIT_INIT : ST_LEN_CHK;
			ST_EMIT_INIT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free && sts.emit_done) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_UPD;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid && (command == CMD_LOAD);
			end
			ST_START: cmd.start = 1'b1;
			ST_UPD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_UPD;
			end
			ST_UPD_WR: begin
				cmd.upd_wr  = 1'b1;
				cmd.idx_clr = sts.idx_last;
				cmd.idx_inc = !sts.idx_last;
			end
			ST_CHK: begin
				cmd.idx_clr  = 1'b1;
				cmd.sel_init = !sts.step_done;
			end
			ST_SEL: begin
				cmd.sel_eval = 1'b1;
				cmd.idx_inc  = !sts.idx_last;
			end
			ST_SEL_END: begin
				cmd.step_inc = sts.pick_zero;
				cmd.set_flag = !sts.pick_zero;
				cmd.ins_init = !sts.pick_zero;
				cmd.idx_clr  = 1'b1;
			end
			ST_INS_CHK: begin
				cmd.rd_en   = sts.ins_ok;
				cmd.rd_sel  = RD_A;
				cmd.idx_inc = !sts.ins_ok && !sts.idx_last;
			end
			ST_INS_RB: begin
				cmd.cap_a  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_B;
			end
			ST_INS_RC: begin
				cmd.cap_b  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_C;
			end
			ST_INS_CMP: begin
				cmd.ins_cmp = 1'b1;
				cmd.idx_inc = !sts.idx_last;
			end
			ST_LINK: begin
				cmd.link     = 1'b1;
				cmd.step_inc = 1'b1;
				cmd.idx_clr  = 1'b1;
			end
			ST_LEN_CHK: begin
				cmd.rd_en   = sts.len_ok;
				cmd.rd_sel  = RD_LEN;
				cmd.idx_inc = !sts.len_ok && !sts.idx_last;
			end
			ST_LEN_ACC: begin
				cmd.len_acc = 1'b1;
				cmd.idx_inc = !sts.idx_last;
			end
			ST_EMIT_INIT: cmd.emit_init = 1'b1;
			ST_EMIT: begin
				cmd.emit_load = sts.out_free;
			end
			default: cmd.load = 1'b0;
		endcase
	end

endmodule

// ----- rtl/tspib_dp.sv -----
module tspib_dp #(
	parameter int MAX_NODES = tspib_pkg::MAX_NODES_DEF,
	parameter int DIST_BITS = tspib_pkg::DIST_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tspib_pkg::dp_cmd_t              cmd,
	output tspib_pkg::dp_sts_t              sts,
	input  logic                            selection_mode,
	input  tspib_pkg::node_t                node_count,
	input  tspib_pkg::node_t                row_node,
	input  tspib_pkg::node_t                col_node,
	input  logic [tspib_pkg::IN_DIST_W-1:0] distance_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tspib_pkg::node_t                tour_node,
	output logic [tspib_pkg::LEN_W-1:0]     tour_length,
	output logic                            last
);
	import tspib_pkg::*;

	localparam int TAB_DEPTH = MAX_NODES * MAX_NODES;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);
	localparam int IDX_W     = $clog2(MAX_NODES + 1);
	localparam int SLOT_W    = $clog2(MAX_NODES);
	localparam int BEST_W    = (DIST_BITS > 28) ? DIST_BITS : 28;
	localparam int COST_W    = (DIST_BITS > 27) ? DIST_BITS + 2 : 30;
	localparam int SUM_W     = (DIST_BITS > LEN_W) ? DIST_BITS + 1 : LEN_W + 1;

	function automatic logic [TAB_AW-1:0] tab_addr(node_t r, node_t c);
		logic [TAB_AW-1:0] rr;
		logic [TAB_AW-1:0] cc;
		rr = TAB_AW'(r - 1'b1);
		cc = TAB_AW'(c - 1'b1);
		return TAB_AW'(rr * TAB_AW'(MAX_NODES)) + cc;
	endfunction

	// City c lives in slot c-1; city 0 has no slot and its successor reads as zero.
	function automatic logic [SLOT_W-1:0] slot(node_t x);
		return SLOT_W'(x - 1'b1);
	endfunction

	logic [DIST_BITS-1:0] table_mem [TAB_DEPTH];
	logic [DIST_BITS-1:0] rd_data_q;
	logic [DIST_BITS-1:0] dtt_q [MAX_NODES];
	node_t                succ_q [MAX_NODES];
	logic [MAX_NODES:0]   flag_q;

	node_t idx_q, step_q, row_q, pick_q, head_q, tail_q, path_q, ecount_q;
	logic [BEST_W-1:0]        best_q;
	logic signed [COST_W-1:0] bestc_q;
	logic [DIST_BITS-1:0]     a_q, b_q;
	logic [LEN_W-1:0]         len_q;
	logic                     out_valid_q, last_q;
	node_t                    tour_node_q;
	logic [LEN_W-1:0]         tour_length_q;

	node_t                    n_eff, succ_cur, succ_path;
	logic [TAB_AW-1:0]        rd_addr;
	logic [DIST_BITS-1:0]     dtt_cur;
	logic                     load_ok, sel_hit, out_free;
	logic signed [COST_W-1:0] cost;
	logic [SUM_W-1:0]         len_sum;

	always_comb begin
		if (node_count < NODE_W'(2)) n_eff = NODE_W'(2);
		else if (node_count > NODE_W'(MAX_NODES)) n_eff = NODE_W'(MAX_NODES);
		else n_eff = node_count;
	end

	assign succ_cur  = succ_q[slot(idx_q)];
	assign succ_path = (path_q == '0) ? '0 : succ_q[slot(path_q)];
	assign dtt_cur   = dtt_q[slot(idx_q)];
	assign load_ok   = cmd.load && row_node != '0 && row_node <= NODE_W'(MAX_NODES)
		&& col_node != '0 && col_node <= NODE_W'(MAX_NODES);

	always_comb begin
		case (cmd.rd_sel)
			RD_UPD:  rd_addr = tab_addr(row_q, idx_q);
			RD_A:    rd_addr = tab_addr(idx_q, pick_q);
			RD_B:    rd_addr = tab_addr(pick_q, succ_cur);
			RD_C:    rd_addr = tab_addr(idx_q, succ_cur);
			RD_LEN:  rd_addr = tab_addr(idx_q, succ_cur);
			default: rd_addr = tab_addr(idx_q, succ_cur);
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			table_mem[tab_addr(row_node, col_node)] <= DIST_BITS'(distance_value);
		end
		if (cmd.rd_en) begin
			rd_data_q <= table_mem[rd_addr];
		end
	end

	// Farthest mode takes the strictly largest nonzero distance, nearest the strictly smallest.
	always_comb begin
		if (selection_mode == MODE_NEAR) sel_hit = BEST_W'(dtt_cur) < best_q;
		else sel_hit = BEST_W'(dtt_cur) > best_q;
		sel_hit = sel_hit && (dtt_cur != '0);
	end

	assign cost = $signed(COST_W'(a_q)) + $signed(COST_W'(b_q))
		- $signed(COST_W'(rd_data_q));
	assign len_sum = SUM_W'(len_q) + SUM_W'(rd_data_q);
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			step_q      <= '0;
			row_q       <= '0;
			pick_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			path_q      <= '0;
			ecount_q    <= '0;
			best_q      <= '0;
			bestc_q     <= '0;
			len_q       <= '0;
			flag_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start || cmd.idx_clr) idx_q <= NODE_W'(1);
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.start) begin
				step_q <= '0;
				row_q  <= NODE_W'(1);
				pick_q <= '0;
				head_q <= '0;
				tail_q <= '0;
				len_q  <= '0;
				flag_q <= (MAX_NODES+1)'(2);
			end
			if (cmd.step_inc) step_q <= step_q + 1'b1;
			if (cmd.sel_init) begin
				best_q <= (selection_mode == MODE_NEAR) ? BEST_W'(BIG_LIMIT) : '0;
			end
			if (cmd.sel_eval && sel_hit) begin
				best_q <= BEST_W'(dtt_cur);
				pick_q <= idx_q;
			end
			if (cmd.set_flag) flag_q[pick_q[IDX_W-1:0]] <= 1'b1;
			if (cmd.ins_init) bestc_q <= $signed(COST_W'(BIG_LIMIT));
			if (cmd.ins_cmp && cost < bestc_q) begin
				bestc_q <= cost;
				head_q  <= succ_cur;
				tail_q  <= idx_q;
			end
			if (cmd.link) row_q <= pick_q;
			if (cmd.len_acc) begin
				len_q <= (len_sum > SUM_W'(LEN_MAX)) ? LEN_MAX : LEN_W'(len_sum);
			end
			if (cmd.emit_init) begin
				path_q   <= NODE_W'(1);
				ecount_q <= '0;
			end
			if (cmd.emit_load) begin
				path_q      <= succ_path;
				ecount_q    <= ecount_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				dtt_q[i]  <= '1;
				succ_q[i] <= '0;
			end
			succ_q[slot(NODE_W'(1))] <= NODE_W'(1);
		end
		if (cmd.upd_wr && rd_data_q < dtt_cur) dtt_q[slot(idx_q)] <= rd_data_q;
		if (cmd.cap_a) a_q <= rd_data_q;
		if (cmd.cap_b) b_q <= rd_data_q;
		if (cmd.link) begin
			succ_q[slot(pick_q)] <= head_q;
			if (tail_q != '0) succ_q[slot(tail_q)] <= pick_q;
		end
		if (cmd.emit_load) begin
			tour_node_q   <= path_q;
			last_q        <= (ecount_q == n_eff);
			tour_length_q <= (ecount_q == n_eff) ? len_q : '0;
		end
	end

	assign sts.idx_last  = (idx_q == n_eff);
	assign sts.step_done = (step_q == n_eff - 1'b1);
	assign sts.pick_zero = (pick_q == '0);
	assign sts.ins_ok    = (idx_q != pick_q) && flag_q[idx_q[IDX_W-1:0]]
		&& (succ_cur != '0) && flag_q[succ_cur[IDX_W-1:0]];
	assign sts.len_ok    = (succ_cur != '0);
	assign sts.emit_done = (ecount_q == n_eff);
	assign sts.out_free  = out_free;

	assign out_valid   = out_valid_q;
	assign tour_node   = tour_node_q;
	assign tour_length = tour_length_q;
	assign last        = last_q;

	a_link_pick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link |-> pick_q != '0)
		else $error("link step without a picked city");
	a_read_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.rd_sel != RD_B) |-> (idx_q != '0 && idx_q <= n_eff))
		else $error("table read with city index out of range");
	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_load && ecount_q == n_eff) |=> (out_valid_q && last_q))
		else $error("final tour beat not flagged");
	a_emit_space: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> out_free)
		else $error("tour beat loaded over a waiting beat");

endmodule
